// File: hdl/gtp_pkg.sv
// Shared types and constants for the go-to-point velocity profile block.
// No dependencies; imported by the datapath, the controller and the top level.
package gtp_pkg;

  localparam int ATAN_N = 24;

  // Arc tangent of 2^-i at 2^32 per full turn.
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic [7:0] REG_TARGET_X      = 8'd0;
  localparam logic [7:0] REG_TARGET_Y      = 8'd1;
  localparam logic [7:0] REG_REVERSE_MODE  = 8'd2;
  localparam logic [7:0] REG_ANG_ACCEL     = 8'd3;
  localparam logic [7:0] REG_ANG_SPEED_MAX = 8'd4;
  localparam logic [7:0] REG_LIN_ACCEL     = 8'd5;
  localparam logic [7:0] REG_LIN_SPEED_MAX = 8'd6;
  localparam logic [7:0] REG_LIN_DECEL     = 8'd7;

  // Divider operand selects.
  localparam logic [1:0] DSEL_THR  = 2'd0;
  localparam logic [1:0] DSEL_AMAG = 2'd1;
  localparam logic [1:0] DSEL_DMAX = 2'd2;

  // Square root operand selects.
  localparam logic SSEL_DIST = 1'b0;
  localparam logic SSEL_LMAG = 1'b1;

  // 0.97 as a 16-bit fraction.
  localparam logic [15:0] DECAY_MUL = 16'd63570;

  typedef struct packed {
    logic       load;
    logic       cordic_init;
    logic       cordic_step;
    logic       err_calc;
    logic       thr_prep;
    logic       div_go;
    logic [1:0] div_sel;
    logic       ang_ramp;
    logic       ang_mag;
    logic       align_upd;
    logic       decay_mul;
    logic       decay;
    logic       sqrt_go;
    logic       sqrt_sel;
    logic       dist_cap;
    logic       lin_ramp;
    logic       lin_prod;
    logic       lin_mag;
    logic       commit;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic div_busy;
    logic sqrt_busy;
    logic ang_far;
    logic al_next;
    logic misaligned;
    logic lin_far;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/gtp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; used by gtp_datapath.
module gtp_div #(
  parameter int NW = 46,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   n;
  logic [DW-1:0]   r;
  logic [DW-1:0]   d;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     rs;
  logic [DW:0]     rd;
  logic            ge;

  always_comb begin
    rs = {r, n[NW-1]};
    ge = rs >= {1'b0, d};
    rd = rs - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      n    <= num;
      r    <= '0;
      d    <= den;
      cnt  <= CNTW'(NW);
      busy <= 1'b1;
    end else if (busy) begin
      n   <= {n[NW-2:0], ge};
      r   <= ge ? rd[DW-1:0] : rs[DW-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = n;

endmodule

// File: hdl/gtp_sqrt.sv
// Integer square root, one result bit (two operand bits) per cycle.
// No dependencies; used by gtp_datapath.
module gtp_sqrt #(
  parameter int NW = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   op,
  output logic            busy,
  output logic [NW/2-1:0] root
);

  localparam int HW   = NW / 2;
  localparam int CNTW = $clog2(HW + 1);

  logic [NW-1:0]   n;
  logic [HW:0]     rem;
  logic [CNTW-1:0] cnt;
  logic [HW+2:0]   rs;
  logic [HW+2:0]   trial;
  logic [HW+2:0]   rd;
  logic            ge;

  always_comb begin
    rs    = {rem, n[NW-1:NW-2]};
    trial = {1'b0, root, 2'b01};
    ge    = rs >= trial;
    rd    = rs - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      n    <= op;
      rem  <= '0;
      root <= '0;
      cnt  <= CNTW'(HW);
      busy <= 1'b1;
    end else if (busy) begin
      n    <= {n[NW-3:0], 2'b00};
      rem  <= ge ? rd[HW:0] : rs[HW:0];
      root <= {root[HW-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/gtp_datapath.sv
// Datapath: configuration registers, CORDIC bearing, speed state and output register.
// Depends on gtp_pkg, gtp_div and gtp_sqrt; driven by gtp_ctrl commands.
module gtp_datapath
  import gtp_pkg::*;
#(
  parameter int CW  = 24,
  parameter int AW  = 16,
  parameter int CS  = 16,
  parameter int TDW = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  dp_cmd_t        cmd,
  output dp_stat_t       stat,
  input  logic           cfg_valid,
  input  logic [7:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic [TDW-1:0] s_tdata,
  input  logic           s_tuser,
  input  logic           m_tready,
  output logic           m_tvalid,
  output logic [47:0]    m_tdata,
  output logic           m_tuser
);

  localparam int AF    = AW + 8;
  localparam int XW    = CW + 20;
  localparam int NSTEP = (CS < ATAN_N) ? CS : ATAN_N;
  localparam int KS    = (CW > 24) ? CW - 24 : 0;
  localparam int AXW   = 25;
  localparam int DIVW  = (46 > AF + 17) ? 46 : AF + 17;
  localparam int SQW   = 64;
  localparam int DSTW  = 33 + KS;
  localparam int PAW   = AF + 17;
  localparam int LPW   = DSTW + 17;
  localparam logic [AF-1:0] TOL  = AF'((64'd1 << AF) / 64'd50);
  localparam logic [AF-1:0] HALF = {1'b1, {(AF - 1){1'b0}}};

  // Configuration.
  logic signed [CW-1:0] tx, ty;
  logic                 rev;
  logic [15:0]          acc_a, acc_l, dec;
  logic [22:0]          vmax_a, vmax_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx     <= '0;
      ty     <= '0;
      rev    <= 1'b0;
      acc_a  <= 16'd16;
      vmax_a <= 23'd4096;
      acc_l  <= 16'd128;
      vmax_l <= 23'd16384;
      dec    <= 16'd70;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET_X:      tx     <= cfg_data[CW-1:0];
        REG_TARGET_Y:      ty     <= cfg_data[CW-1:0];
        REG_REVERSE_MODE:  rev    <= cfg_data[0];
        REG_ANG_ACCEL:     acc_a  <= cfg_data[15:0];
        REG_ANG_SPEED_MAX: vmax_a <= cfg_data[22:0];
        REG_LIN_ACCEL:     acc_l  <= cfg_data[15:0];
        REG_LIN_SPEED_MAX: vmax_l <= cfg_data[22:0];
        REG_LIN_DECEL:     dec    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // A rate register of zero behaves as one.
  logic [15:0] acc_a_e, acc_l_e, dec_e;
  logic [22:0] vmax_a_e, vmax_l_e;
  logic [16:0] acc2_a, dec2;

  always_comb begin
    acc_a_e  = (acc_a == '0) ? 16'd1 : acc_a;
    acc_l_e  = (acc_l == '0) ? 16'd1 : acc_l;
    dec_e    = (dec == '0) ? 16'd1 : dec;
    vmax_a_e = (vmax_a == '0) ? 23'd1 : vmax_a;
    vmax_l_e = (vmax_l == '0) ? 23'd1 : vmax_l;
    acc2_a   = {acc_a_e, 1'b0};
    dec2     = {dec_e, 1'b0};
  end

  function automatic logic signed [23:0] ramp_clamp(logic signed [23:0] v, logic [15:0] a,
                                                    logic neg, logic [22:0] lim);
    logic signed [25:0] s;
    logic signed [25:0] l;
    logic signed [25:0] st;
    st = $signed({10'b0, a});
    s  = {{2{v[23]}}, v} + (neg ? -st : st);
    l  = $signed({3'b0, lim});
    if (s > l) begin
      ramp_clamp = l[23:0];
    end else if (s < -l) begin
      ramp_clamp = 24'(-l);
    end else begin
      ramp_clamp = s[23:0];
    end
  endfunction

  // Working registers.
  logic signed [CW:0]   dx, dy;
  logic [AW-1:0]        head;
  logic signed [XW-1:0] x, y;
  logic [31:0]          z;
  logic [4:0]           cnt;
  logic                 zflag;
  logic [AF-1:0]        aerr;
  logic                 epos, eneg;
  logic [45:0]          vsq;
  logic [49:0]          sqx, sqy;
  logic [63:0]          prod;
  logic [DSTW-1:0]      dst8;

  // Speed state.
  logic signed [23:0]   ang, lin;
  logic                 al;

  // Shared arithmetic units.
  logic              div_go, div_busy;
  logic [DIVW-1:0]   div_num, div_quo;
  logic [23:0]       div_den;
  logic              sq_go, sq_busy;
  logic [SQW-1:0]    sq_op;
  logic [SQW/2-1:0]  sq_root;

  gtp_div #(.NW(DIVW), .DW(24)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );

  gtp_sqrt #(.NW(SQW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_go), .op(sq_op), .busy(sq_busy), .root(sq_root)
  );

  // Combinational helpers.
  logic signed [XW-1:0] x0, y0;
  logic                 y_pos;
  logic [AF-1:0]        bsel, dd;
  logic [CW:0]          abs_dx, abs_dy;
  logic [AXW-1:0]       ax, ay;
  logic [23:0]          abs_lin;
  logic [23:0]          dmag;
  logic [23:0]          qmag;
  logic [23:0]          rmag;

  always_comb begin
    x0     = {{3{dx[CW]}}, dx, 16'b0};
    y0     = {{3{dy[CW]}}, dy, 16'b0};
    y_pos  = !y[XW-1] && (y != '0);
    bsel   = zflag ? '0 : z[31 -: AF];
    if (rev) begin
      bsel = bsel + HALF;
    end
    dd     = bsel - {head, 8'b0};
    abs_dx = dx[CW] ? -dx : dx;
    abs_dy = dy[CW] ? -dy : dy;
    ax     = AXW'(abs_dx >> KS);
    ay     = AXW'(abs_dy >> KS);
    abs_lin = lin[23] ? -lin : lin;
    dmag   = prod[39:16];
    qmag   = div_quo[23:0];
    rmag   = sq_root[23:0];

    div_go  = cmd.div_go;
    div_num = DIVW'(vsq);
    div_den = {7'b0, acc2_a};
    case (cmd.div_sel)
      DSEL_THR: begin
        div_num = DIVW'(vsq);
        div_den = {7'b0, acc2_a};
      end
      DSEL_AMAG: begin
        div_num = prod[DIVW-1:0];
        div_den = {1'b0, vmax_a_e};
      end
      DSEL_DMAX: begin
        div_num = DIVW'(vsq);
        div_den = {7'b0, dec2};
      end
      default: ;
    endcase

    sq_go = cmd.sqrt_go;
    sq_op = (cmd.sqrt_sel == SSEL_DIST) ? ((64'(sqx) + 64'(sqy)) << 14) : prod;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx   <= {tx[CW-1], tx} - {s_tdata[CW-1], s_tdata[CW-1:0]};
      dy   <= {ty[CW-1], ty} - {s_tdata[2*CW-1], s_tdata[2*CW-1:CW]};
      head <= s_tdata[2*CW+AW-1:2*CW];
    end
    if (cmd.cordic_init) begin
      zflag <= (dx == '0) && (dy == '0);
      cnt   <= '0;
      if (dx[CW]) begin
        x <= -x0;
        y <= -y0;
        z <= 32'h80000000;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end
    if (cmd.cordic_step) begin
      cnt <= cnt + 1'b1;
      if (y_pos) begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        z <= z + ATAN_TAB[cnt];
      end else begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        z <= z - ATAN_TAB[cnt];
      end
    end
    if (cmd.err_calc) begin
      aerr <= dd[AF-1] ? -dd : dd;
      epos <= !dd[AF-1] && (dd != '0);
      eneg <= dd[AF-1];
      vsq  <= 46'(vmax_a_e) * 46'(vmax_a_e);
      sqx  <= 50'(ax) * 50'(ax);
      sqy  <= 50'(ay) * 50'(ay);
    end
    if (cmd.thr_prep) begin
      prod <= 64'(PAW'(aerr) * PAW'(acc2_a));
    end
    if (cmd.decay_mul) begin
      prod <= 64'(40'(abs_lin) * 40'(DECAY_MUL));
    end
    if (cmd.dist_cap) begin
      dst8 <= {sq_root, {(1 + KS){1'b0}}};
      vsq  <= 46'(vmax_l_e) * 46'(vmax_l_e);
    end
    if (cmd.lin_prod) begin
      prod <= 64'(LPW'(dst8) * LPW'(dec2));
    end
  end

  // Speed state; a start command clears it as the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ang <= '0;
      lin <= '0;
      al  <= 1'b0;
    end else begin
      if (cmd.load && s_tuser) begin
        ang <= '0;
        lin <= '0;
        al  <= 1'b0;
      end
      if (cmd.ang_ramp) begin
        ang <= ramp_clamp(ang, acc_a_e, !epos, vmax_a_e);
      end
      if (cmd.ang_mag) begin
        ang <= eneg ? -qmag : qmag;
      end
      if (cmd.align_upd) begin
        al <= stat.al_next;
      end
      if (cmd.decay) begin
        lin <= lin[23] ? -dmag : dmag;
      end
      if (cmd.lin_ramp) begin
        lin <= ramp_clamp(lin, acc_l_e, rev, vmax_l_e);
      end
      if (cmd.lin_mag) begin
        lin <= rev ? -rmag : rmag;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {ang, lin};
      m_tuser <= al;
    end
  end

  always_comb begin
    stat.cordic_last = (cnt == 5'(NSTEP - 1));
    stat.div_busy    = div_busy;
    stat.sqrt_busy   = sq_busy;
    stat.ang_far     = DIVW'(aerr) > div_quo;
    stat.al_next     = al || (aerr < TOL);
    stat.misaligned  = aerr > TOL;
    stat.lin_far     = 64'(dst8) > 64'(div_quo);
    stat.out_free    = !m_tvalid || m_tready;
  end

endmodule

// File: hdl/gtp_ctrl.sv
// Sequencer that steps one control tick through the datapath.
// Depends on gtp_pkg; drives gtp_datapath with commands and reads its status.
module gtp_ctrl
  import gtp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_CORD   = 5'd2;
  localparam logic [4:0] S_ERR    = 5'd3;
  localparam logic [4:0] S_THR    = 5'd4;
  localparam logic [4:0] S_THR_W  = 5'd5;
  localparam logic [4:0] S_ANG    = 5'd6;
  localparam logic [4:0] S_AMAG_W = 5'd7;
  localparam logic [4:0] S_LIN    = 5'd8;
  localparam logic [4:0] S_DECAY  = 5'd9;
  localparam logic [4:0] S_DIST_W = 5'd10;
  localparam logic [4:0] S_DMAX   = 5'd11;
  localparam logic [4:0] S_DMAX_W = 5'd12;
  localparam logic [4:0] S_LDEC   = 5'd13;
  localparam logic [4:0] S_LMAG   = 5'd14;
  localparam logic [4:0] S_LMAG_W = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.div_sel = DSEL_THR;
    cmd.sqrt_sel = SSEL_DIST;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.cordic_init = 1'b1;
        state_next      = S_CORD;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        if (stat.cordic_last) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_calc = 1'b1;
        state_next   = S_THR;
      end
      S_THR: begin
        cmd.thr_prep = 1'b1;
        cmd.div_go   = 1'b1;
        cmd.div_sel  = DSEL_THR;
        state_next   = S_THR_W;
      end
      S_THR_W: begin
        if (!stat.div_busy) begin
          state_next = S_ANG;
        end
      end
      S_ANG: begin
        if (stat.ang_far) begin
          cmd.ang_ramp = 1'b1;
          state_next   = S_LIN;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DSEL_AMAG;
          state_next  = S_AMAG_W;
        end
      end
      S_AMAG_W: begin
        if (!stat.div_busy) begin
          cmd.ang_mag = 1'b1;
          state_next  = S_LIN;
        end
      end
      S_LIN: begin
        cmd.align_upd = 1'b1;
        if (!stat.al_next) begin
          state_next = S_DONE;
        end else if (stat.misaligned) begin
          cmd.decay_mul = 1'b1;
          state_next    = S_DECAY;
        end else begin
          cmd.sqrt_go  = 1'b1;
          cmd.sqrt_sel = SSEL_DIST;
          state_next   = S_DIST_W;
        end
      end
      S_DECAY: begin
        cmd.decay  = 1'b1;
        state_next = S_DONE;
      end
      S_DIST_W: begin
        if (!stat.sqrt_busy) begin
          cmd.dist_cap = 1'b1;
          state_next   = S_DMAX;
        end
      end
      S_DMAX: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DSEL_DMAX;
        state_next  = S_DMAX_W;
      end
      S_DMAX_W: begin
        if (!stat.div_busy) begin
          state_next = S_LDEC;
        end
      end
      S_LDEC: begin
        if (stat.lin_far) begin
          cmd.lin_ramp = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.lin_prod = 1'b1;
          state_next   = S_LMAG;
        end
      end
      S_LMAG: begin
        cmd.sqrt_go  = 1'b1;
        cmd.sqrt_sel = SSEL_LMAG;
        state_next   = S_LMAG_W;
      end
      S_LMAG_W: begin
        if (!stat.sqrt_busy) begin
          cmd.lin_mag = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/go_to_point_velocity_profile.sv
// Go-to-point velocity profile: one speed command item per pose item.
// One item at a time: the next can be taken in the cycle after the result enters the output
// register. Synchronous reset clears speeds and the aligned flag.
module go_to_point_velocity_profile
  import gtp_pkg::*;
#(
  parameter int COORD_WIDTH  = 24,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16,
  localparam int TDW = ((2 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // robot_x, robot_y, robot_heading, zero fill
  input  logic [TDW-1:0] s_axis_tdata,
  // start_command
  input  logic           s_axis_tuser,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // linear_speed[23:0], angular_speed[47:24]
  output logic [47:0]    m_axis_tdata,
  // aligned
  output logic           m_axis_tuser,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gtp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  gtp_datapath #(
    .CW(COORD_WIDTH), .AW(ANGLE_WIDTH), .CS(CORDIC_STEPS), .TDW(TDW)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
    .m_tready(m_axis_tready), .m_tvalid(m_axis_tvalid),
    .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over an undelivered item");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> !stat.div_busy)
    else $error("divider started while busy");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_go |-> !stat.sqrt_busy)
    else $error("square root started while busy");

endmodule

// File: verif/go_to_point_velocity_profile_tb.sv
// Self-checking testbench for the go-to-point velocity profile block.
// Depends on gtp_pkg and go_to_point_velocity_profile; predicts every speed item in place.
`timescale 1ns / 100ps

module go_to_point_velocity_profile_tb
  import gtp_pkg::*;
();

  localparam int CW  = 24;
  localparam int AW  = 16;
  localparam int TDW = ((2 * CW + AW + 7) / 8) * 8;
  localparam longint FULL_TURN = 64'd1 << (AW + 8);

  typedef struct packed {
    logic [23:0] lin;
    logic [23:0] ang;
    logic        aligned;
  } speed_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [TDW-1:0] s_axis_tdata = '0;
  logic           s_axis_tuser = 1'b0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [47:0]    m_axis_tdata;
  logic           m_axis_tuser;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [7:0]     cfg_index = '0;
  logic [31:0]    cfg_data = '0;

  go_to_point_velocity_profile u_dut (.*);

  always #2 clk = ~clk;

  // Predictor copy of configuration and state.
  longint tgt_x, tgt_y, rev, acc_a, vmax_a, acc_l, vmax_l, decel;
  longint ang_reg, lin_reg;
  bit     al_flag;

  speed_t speed_q[$];
  int     errors, results, accepted;
  int     send_idle_pct, recv_stall_pct;
  bit     recv_hold;

  function automatic longint shr_s(longint v, int s);
    return v >= 0 ? (v >>> s) : ~((~v) >>> s);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint bearing(longint dx, longint dy);
    longint x, y, nx;
    logic [31:0] z;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 65536;
    y = dy * 65536;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + shr_s(y, i);
        y = y - shr_s(x, i);
        z = z + ATAN_TAB[i];
      end else begin
        nx = x - shr_s(y, i);
        y = y + shr_s(x, i);
        z = z - ATAN_TAB[i];
      end
      x = nx;
    end
    return longint'(z >> (24 - AW));
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void cfg_model(logic [7:0] idx, logic [31:0] val);
    case (idx)
      REG_TARGET_X:      tgt_x = longint'(signed'(val[23:0]));
      REG_TARGET_Y:      tgt_y = longint'(signed'(val[23:0]));
      REG_REVERSE_MODE:  rev = val[0];
      REG_ANG_ACCEL:     acc_a = val[15:0];
      REG_ANG_SPEED_MAX: vmax_a = val[22:0];
      REG_LIN_ACCEL:     acc_l = val[15:0];
      REG_LIN_SPEED_MAX: vmax_l = val[22:0];
      REG_LIN_DECEL:     decel = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic speed_t next_speeds(bit start, logic [23:0] rx, logic [23:0] ry,
                                         logic [15:0] hd);
    longint aa, va, al, vl, dc, dx, dy, b, d, err, aerr, thr, tol, mag, s, dist8, dmax8;
    speed_t r;
    if (start) begin
      ang_reg = 0;
      lin_reg = 0;
      al_flag = 0;
    end
    aa = acc_a ? acc_a : 1;
    va = vmax_a ? vmax_a : 1;
    al = acc_l ? acc_l : 1;
    vl = vmax_l ? vmax_l : 1;
    dc = decel ? decel : 1;
    dx = tgt_x - longint'(signed'(rx));
    dy = tgt_y - longint'(signed'(ry));
    b = bearing(dx, dy);
    if (rev) b = b + FULL_TURN / 2;
    d = (b - (longint'(hd) << 8)) & (FULL_TURN - 1);
    err = d >= FULL_TURN / 2 ? d - FULL_TURN : d;
    aerr = err < 0 ? -err : err;
    thr = (va * va) / (2 * aa);
    if (aerr > thr) begin
      ang_reg = clip(ang_reg + (err > 0 ? aa : -aa), va);
    end else begin
      mag = aerr * 2 * aa / va;
      ang_reg = err < 0 ? -mag : mag;
    end
    tol = FULL_TURN / 50;
    if (!al_flag && aerr < tol) al_flag = 1;
    if (al_flag) begin
      if (aerr > tol) begin
        mag = lin_reg < 0 ? -lin_reg : lin_reg;
        mag = (mag * 63570) >> 16;
        lin_reg = lin_reg < 0 ? -mag : mag;
      end else begin
        s = dx * dx + dy * dy;
        dist8 = int_sqrt(s << 14) << 1;
        dmax8 = (vl * vl) / (2 * dc);
        if (dist8 > dmax8) begin
          lin_reg = clip(lin_reg + (rev ? -al : al), vl);
        end else begin
          mag = int_sqrt(2 * dist8 * dc);
          lin_reg = rev ? -mag : mag;
        end
      end
    end
    r.lin = lin_reg[23:0];
    r.ang = ang_reg[23:0];
    r.aligned = al_flag;
    return r;
  endfunction

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_model(idx, val);
  endtask

  // The valid line stays up after an accept and drops on the next idle cycle or in drain,
  // so back-to-back items never assign it twice in one time step.
  task automatic send_pose(bit start, logic [23:0] rx, logic [23:0] ry, logic [15:0] hd);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {{(TDW - 64){1'b0}}, hd, ry, rx};
    s_axis_tuser  <= start;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    speed_q.push_back(next_speeds(start, rx, ry, hd));
    accepted++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (speed_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Receiver: random stalls unless a long hold is requested.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    speed_t exp_s;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results++;
      if (speed_q.size() == 0) begin
        $error("speed item with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        exp_s = speed_q.pop_front();
        if (m_axis_tdata[23:0] !== exp_s.lin) begin
          $error("linear_speed expected %h got %h", exp_s.lin, m_axis_tdata[23:0]);
          errors++;
        end
        if (m_axis_tdata[47:24] !== exp_s.ang) begin
          $error("angular_speed expected %h got %h", exp_s.ang, m_axis_tdata[47:24]);
          errors++;
        end
        if (m_axis_tuser !== exp_s.aligned) begin
          $error("aligned expected %b got %b", exp_s.aligned, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // A pose near the target, heading roughly toward it, so the linear profile engages.
  task automatic send_approach(bit start, int spread);
    longint rx, ry, hd;
    rx = tgt_x - $signed($urandom_range(2 * spread)) + spread;
    ry = tgt_y - $signed($urandom_range(2 * spread)) + spread;
    rx = clip(rx, 8388607);
    ry = clip(ry, 8388607);
    hd = bearing(tgt_x - rx, tgt_y - ry) >> 8;
    if (rev) hd = hd + 32768;
    hd = hd + $signed($urandom_range(2000)) - 1000;
    send_pose(start, rx[23:0], ry[23:0], hd[15:0]);
  endtask

  task automatic test_directed();
    send_pose(1, 0, 0, 0);                      // robot on target
    send_pose(0, 24'h7FFFFF, 24'h800000, 16'hFFFF);
    send_pose(0, 24'h800000, 24'h7FFFFF, 16'h8000);
    send_pose(0, 24'hFFFFFF, 24'h000001, 16'h0001);
    send_pose(1, -24'sd1000, 0, 0);             // straight ahead, aligned
    for (int i = 0; i < 6; i++) send_pose(0, 24'(-1000 + i * 10), 0, 0);
    send_pose(0, -24'sd900, 0, 16'd1311);       // error just past the tolerance
    send_pose(0, -24'sd900, 0, 16'd1400);       // misaligned: decay
    send_pose(0, 0, -24'sd2000, 16'h4000);
    send_pose(0, 24'sd3, 24'sd3, 16'hA000);
    drain();
    // Zero rate registers count as one; reverse travel.
    write_reg(REG_ANG_ACCEL, 0);
    write_reg(REG_ANG_SPEED_MAX, 0);
    write_reg(REG_LIN_ACCEL, 0);
    write_reg(REG_LIN_SPEED_MAX, 0);
    write_reg(REG_LIN_DECEL, 0);
    write_reg(REG_REVERSE_MODE, 1);
    write_reg(8'd200, 32'hFFFFFFFF);            // unknown index is ignored
    send_pose(1, 24'sd500, 0, 0);
    send_pose(0, 24'sd400, 0, 0);
    send_pose(0, 24'sd300, 24'sd5, 16'hFF00);
    drain();
  endtask

  task automatic test_random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7)
        send_approach($urandom_range(29) == 0, $urandom_range(1) ? 64 : 200000);
      else
        send_pose(1'($urandom_range(1)), 24'($urandom), 24'($urandom), 16'($urandom));
    end
    drain();
  endtask

  task automatic random_config(bit extreme);
    write_reg(REG_TARGET_X, extreme ? ($urandom_range(1) ? 32'h7FFFFF : 32'h800000) : $urandom);
    write_reg(REG_TARGET_Y, extreme ? ($urandom_range(1) ? 32'h7FFFFF : 32'h800000) : $urandom);
    write_reg(REG_REVERSE_MODE, $urandom);
    write_reg(REG_ANG_ACCEL, extreme ? 32'hFFFF : $urandom_range(200, 1));
    write_reg(REG_ANG_SPEED_MAX, extreme ? 32'h7FFFFF : $urandom_range(20000, 1));
    write_reg(REG_LIN_ACCEL, extreme ? 32'hFFFF : $urandom_range(2000, 1));
    write_reg(REG_LIN_SPEED_MAX, extreme ? 32'h7FFFFF : $urandom_range(100000, 1));
    write_reg(REG_LIN_DECEL, extreme ? 32'hFFFF : $urandom_range(2000, 1));
  endtask

  task automatic test_backpressure();
    // Receiver holds off long while the sender keeps offering items.
    recv_hold = 1;
    fork
      repeat (3) send_approach(0, 500);
      begin
        repeat (2000) @(posedge clk);
        recv_hold = 0;
      end
    join
    drain();
  endtask

  initial begin
    tgt_x = 0; tgt_y = 0; rev = 0;
    acc_a = 16; vmax_a = 4096; acc_l = 128; vmax_l = 16384; decel = 70;
    ang_reg = 0; lin_reg = 0; al_flag = 0;
    send_idle_pct = 0; recv_stall_pct = 0; recv_hold = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    random_config(0);
    test_random_phase(200);
    send_idle_pct = 84;
    random_config(1);
    test_random_phase(150);
    send_idle_pct = 0; recv_stall_pct = 84;
    random_config(0);
    test_random_phase(200);
    send_idle_pct = 6; recv_stall_pct = 6;
    random_config(0);
    test_random_phase(280);
    $display("Covered %0d pose items and %0d speed items over directed cases, back-pressure,",
             accepted, results);
    $display("and random phases with varied, extreme and zero register settings.");
    if (errors == 0) $display("[go_to_point_velocity_profile] OK");
    else $display("[go_to_point_velocity_profile] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[go_to_point_velocity_profile] ERROR");
    $finish;
  end

endmodule

// File: sim.f
hdl/gtp_pkg.sv
hdl/gtp_div.sv
hdl/gtp_sqrt.sv
hdl/gtp_datapath.sv
hdl/gtp_ctrl.sv
hdl/go_to_point_velocity_profile.sv
verif/go_to_point_velocity_profile_tb.sv
